/* design/b64sc_pkg.sv */
`default_nettype none

package b64sc_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam int unsigned MAX_RES = 4;

    typedef logic [7:0] t_byte;
    typedef logic [5:0] t_sextet;

    function automatic t_byte b64_char(input t_sextet v);
        t_byte c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // Bit 6 set marks a character outside the alphabet.
    function automatic logic [6:0] b64_sextet(input t_byte c);
        logic [6:0] v;
        case (c) inside
            [8'h41:8'h5A]: v = 7'(c - 8'h41);
            [8'h61:8'h7A]: v = 7'(c - 8'h61 + 8'd26);
            [8'h30:8'h39]: v = 7'(c - 8'h30 + 8'd52);
            8'h2B:         v = 7'd62;
            8'h2F:         v = 7'd63;
            default:       v = 7'd64;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* design/base64_stream_codec.sv */
// Base64 codec on a valid/stall stream, one beat in and zero to four beats out.
// i_cfg_wen writes i_cfg_data into the mode register: 0 encodes raw bytes to
// base64 characters, 1 decodes characters to bytes. A write clears all message
// state; the user must make it only while the block is idle (not enforced here).
// Input beats carry a byte and a last flag; output beats carry a byte, a last
// flag and a sticky error flag that is only ever set when decoding.
// The results of a beat are loaded into the output register as it is accepted.
// A beat that gives no result lets the next beat in on the following cycle, and
// one that gives one result does too unless the receiver stalls, so the block
// takes one beat per cycle while it is not stalled; a beat that gives several
// results lets the next beat in only as its last result leaves.
// Each decoded byte is held back until the next one is decoded or the last beat
// arrives, so that the final byte can carry the last flag.
// While i_out_stall is high the current result holds and o_in_stall rises as
// soon as no further result can be taken in; nothing is dropped.
// Reset (synchronous, active low) selects encoding, clears the message state
// and empties the result register.
`default_nettype none

module base64_stream_codec (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wen,
    input  wire logic             i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire b64sc_pkg::t_byte i_in_byte,
    input  wire logic             i_in_last,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output b64sc_pkg::t_byte      o_out_byte,
    output logic                  o_out_last,
    output logic                  o_bad_input
);
    import b64sc_pkg::*;

    logic        r_mode;
    logic [5:0]  r_left;
    logic [1:0]  r_phase;
    logic [1:0]  r_pad;
    logic        r_err;
    logic        r_hold_vld;
    t_byte       r_hold_byte;

    logic [5:0]  n_left;
    logic [1:0]  n_phase;
    logic [1:0]  n_pad;
    logic        n_err;
    logic        n_hold_vld;
    t_byte       n_hold_byte;

    t_byte       r_res_byte [MAX_RES];
    logic        r_res_last [MAX_RES];
    logic        r_res_bad;
    logic [2:0]  r_rem;
    logic [1:0]  r_ptr;

    t_byte       n_res_byte [MAX_RES];
    logic        n_res_last [MAX_RES];
    logic        n_res_bad;
    logic [2:0]  n_cnt;

    logic        in_fire;
    logic        out_fire;
    logic [6:0]  dec_raw;
    logic [5:0]  dec_v;
    t_byte       dec_nb;
    logic        dec_made;

    assign o_out_valid = (r_rem != 3'd0);
    assign out_fire    = o_out_valid && !i_out_stall;
    assign o_in_stall  = !((r_rem == 3'd0) || ((r_rem == 3'd1) && out_fire));
    assign in_fire     = i_in_valid && !o_in_stall;

    assign o_out_byte  = r_res_byte[r_ptr];
    assign o_out_last  = r_res_last[r_ptr];
    assign o_bad_input = r_res_bad;

    assign dec_raw = b64_sextet(i_in_byte);
    assign dec_v   = dec_raw[6] ? 6'd0 : dec_raw[5:0];

    always_comb begin
        n_left      = r_left;
        n_phase     = r_phase;
        n_pad       = r_pad;
        n_err       = r_err;
        n_hold_vld  = r_hold_vld;
        n_hold_byte = r_hold_byte;
        n_res_bad   = 1'b0;
        n_cnt       = 3'd0;
        dec_nb      = '0;
        dec_made    = 1'b0;
        for (int k = 0; k < MAX_RES; k++) begin
            n_res_byte[k] = '0;
            n_res_last[k] = 1'b0;
        end

        if (!r_mode) begin
            case (r_phase)
                2'd0: begin
                    n_res_byte[0] = b64_char(i_in_byte[7:2]);
                    n_left        = {i_in_byte[1:0], 4'b0000};
                    n_phase       = 2'd1;
                    n_cnt         = 3'd1;
                    if (i_in_last) begin
                        n_res_byte[1] = b64_char({i_in_byte[1:0], 4'b0000});
                        n_res_byte[2] = PAD_CHAR;
                        n_res_byte[3] = PAD_CHAR;
                        n_res_last[3] = 1'b1;
                        n_cnt         = 3'd4;
                    end
                end
                2'd1: begin
                    n_res_byte[0] = b64_char({r_left[5:4], i_in_byte[7:4]});
                    n_left        = {i_in_byte[3:0], 2'b00};
                    n_phase       = 2'd2;
                    n_cnt         = 3'd1;
                    if (i_in_last) begin
                        n_res_byte[1] = b64_char({i_in_byte[3:0], 2'b00});
                        n_res_byte[2] = PAD_CHAR;
                        n_res_last[2] = 1'b1;
                        n_cnt         = 3'd3;
                    end
                end
                default: begin
                    n_res_byte[0] = b64_char({r_left[5:2], i_in_byte[7:6]});
                    n_res_byte[1] = b64_char(i_in_byte[5:0]);
                    n_res_last[1] = i_in_last;
                    n_left        = '0;
                    n_phase       = 2'd0;
                    n_cnt         = 3'd2;
                end
            endcase
        end else begin
            if (i_in_byte == PAD_CHAR) begin
                if (r_phase < 2'd2) begin
                    n_err = 1'b1;
                end
                if (r_pad != 2'd3) begin
                    n_pad = r_pad + 2'd1;
                end
            end else if (r_pad != 2'd0) begin
                n_err = 1'b1;
            end else begin
                if (dec_raw[6]) begin
                    n_err = 1'b1;
                end
                case (r_phase)
                    2'd0: begin
                        n_left = dec_v;
                    end
                    2'd1: begin
                        dec_nb   = {r_left[5:0], dec_v[5:4]};
                        n_left   = {2'b00, dec_v[3:0]};
                        dec_made = 1'b1;
                    end
                    2'd2: begin
                        dec_nb   = {r_left[3:0], dec_v[5:2]};
                        n_left   = {4'b0000, dec_v[1:0]};
                        dec_made = 1'b1;
                    end
                    default: begin
                        dec_nb   = {r_left[1:0], dec_v};
                        n_left   = '0;
                        dec_made = 1'b1;
                    end
                endcase
            end
            n_phase = r_phase + 2'd1;
            if (i_in_last && (n_phase != 2'd0)) begin
                n_err = 1'b1;
            end
            n_res_bad = n_err;

            if (dec_made) begin
                if (r_hold_vld) begin
                    n_res_byte[0] = r_hold_byte;
                    n_cnt         = 3'd1;
                end
                if (i_in_last) begin
                    n_res_byte[n_cnt[1:0]] = dec_nb;
                    n_res_last[n_cnt[1:0]] = 1'b1;
                    n_cnt                  = n_cnt + 3'd1;
                end else begin
                    n_hold_byte = dec_nb;
                    n_hold_vld  = 1'b1;
                end
            end else if (i_in_last) begin
                n_res_byte[0] = r_hold_vld ? r_hold_byte : 8'd0;
                n_res_last[0] = 1'b1;
                n_cnt         = 3'd1;
            end
        end

        if (i_in_last) begin
            n_left     = '0;
            n_phase    = '0;
            n_pad      = '0;
            n_err      = 1'b0;
            n_hold_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_left     <= '0;
            r_phase    <= '0;
            r_pad      <= '0;
            r_err      <= 1'b0;
            r_hold_vld <= 1'b0;
            r_rem      <= '0;
            r_ptr      <= '0;
        end else begin
            if (i_cfg_wen) begin
                r_mode     <= i_cfg_data;
                r_left     <= '0;
                r_phase    <= '0;
                r_pad      <= '0;
                r_err      <= 1'b0;
                r_hold_vld <= 1'b0;
            end else if (in_fire) begin
                r_left     <= n_left;
                r_phase    <= n_phase;
                r_pad      <= n_pad;
                r_err      <= n_err;
                r_hold_vld <= n_hold_vld;
            end
            if (in_fire) begin
                r_rem <= n_cnt;
                r_ptr <= '0;
            end else if (out_fire) begin
                r_rem <= r_rem - 3'd1;
                r_ptr <= r_ptr + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_hold_byte <= n_hold_byte;
            r_res_bad   <= n_res_bad;
            for (int k = 0; k < MAX_RES; k++) begin
                r_res_byte[k] <= n_res_byte[k];
                r_res_last[k] <= n_res_last[k];
            end
        end
    end

endmodule

`default_nettype wire
